### rtl/mhpq_pkg.sv
package mhpq_pkg;

   localparam int ID_W    = 16;
   localparam int PCT_W   = 15;
   localparam int KEY_W   = 17;
   localparam int OCC_W   = 7;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = 40;

   localparam logic [PCT_W-1:0] PCT_MAX = 15'd25600;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_EXTRACT = 2'd1,
      FUNC_UPDATE  = 2'd2
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
   } entry_type;

   typedef enum logic [2:0] {
      RD_ROOT   = 3'd0,
      RD_NEXT   = 3'd1,
      RD_PARENT = 3'd2,
      RD_LAST   = 3'd3,
      RD_LEFT   = 3'd4,
      RD_RIGHT  = 3'd5
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ITEM   = 2'd0,
      WR_PARENT = 2'd1,
      WR_CHILD  = 2'd2
   } wr_sel_type;

   typedef enum logic [2:0] {
      NODE_HOLD   = 3'd0,
      NODE_COUNT  = 3'd1,
      NODE_IDX    = 3'd2,
      NODE_PARENT = 3'd3,
      NODE_ZERO   = 3'd4,
      NODE_CHILD  = 3'd5
   } node_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      node_sel_type node_sel;
      logic         count_inc;
      logic         count_dec;
      logic         idx_inc;
      logic         item_from_rdata;
      logic         latch_out;
      logic         latch_child;
      logic         moved_set;
      logic         status_set;
      status_type   status_code;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     count_zero;
      logic     count_full;
      logic     node_zero;
      logic     parent_less;
      logic     id_match;
      logic     search_last;
      logic     left_in;
      logic     right_in;
      logic     down_move;
      logic     moved;
      logic     rsp_free;
   } sts_type;

   function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
      return (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

endpackage

### rtl/max_heap_priority_queue_update_unit.sv
// An insert sifts the new entry up from the first free slot; an extract takes the root and sifts the
// last entry down from the root; an update searches the entries in index order for the id, sifts it up,
// and sifts it down if it did not rise; a refused insert, an empty extract or update, an absent id and
// the unused func end with a zero entry in the result.
// One operation at a time; the next beat can be taken in the cycle after the result loads, even while that
// result beat waits. Synchronous reset empties the heap; entry memory contents are not cleared.
module max_heap_priority_queue_update_unit #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // func
   input  logic [mhpq_pkg::FUNC_W-1:0]  req_tuser,
   // entry_id, sales_pct, satisfaction_pct, completion_pct, zero fill
   input  logic [mhpq_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // status
   output logic [mhpq_pkg::STAT_W-1:0]  rsp_tuser,
   // out_id, out_key, occupancy
   output logic [mhpq_pkg::RSP_W-1:0]   rsp_tdata
);

   mhpq_pkg::cmd_type cmd;
   mhpq_pkg::sts_type sts;

   mhpq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mhpq_datapath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

### rtl/mhpq_datapath.sv
module mhpq_datapath #(
   parameter int HEAP_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mhpq_pkg::FUNC_W-1:0]  req_tuser,
   input  logic [mhpq_pkg::REQ_W-1:0]   req_tdata,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [mhpq_pkg::STAT_W-1:0]  rsp_tuser,
   output logic [mhpq_pkg::RSP_W-1:0]   rsp_tdata,
   input  mhpq_pkg::cmd_type            cmd,
   output mhpq_pkg::sts_type            sts
);

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int CH_W  = IDX_W + 2;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HEAP_DEPTH);

   mhpq_pkg::entry_type heap_mem [HEAP_DEPTH];
   mhpq_pkg::entry_type rdata_ff;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          node_ff, node_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   mhpq_pkg::entry_type       item_ff, item_in;
   mhpq_pkg::entry_type       child_ff, child_in;
   mhpq_pkg::func_type        func_ff, func_in;
   logic                      moved_ff, moved_in;
   mhpq_pkg::status_type      status_ff, status_in;
   mhpq_pkg::entry_type       out_ff, out_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::status_type      rsp_status_ff, rsp_status_in;
   mhpq_pkg::entry_type       rsp_out_ff, rsp_out_in;
   logic [mhpq_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic [mhpq_pkg::KEY_W-1:0] key_sum;
   logic [CH_W-1:0]           left_w, right_w, count_w;
   logic [IDX_W-1:0]          node_m1, parent_idx, idx_next, last_idx;
   logic [CNT_W-1:0]          count_m1;
   logic [IDX_W-1:0]          rd_addr;
   mhpq_pkg::entry_type       wr_data;
   logic                      left_gt, right_gt;
   logic [mhpq_pkg::KEY_W-1:0] best_key;
   logic                      rsp_free;

   // key is the exact sum of the three saturated percentages
   assign key_sum = mhpq_pkg::KEY_W'(mhpq_pkg::sat_pct(req_tdata[30:16]))
                  + mhpq_pkg::KEY_W'(mhpq_pkg::sat_pct(req_tdata[45:31]))
                  + mhpq_pkg::KEY_W'(mhpq_pkg::sat_pct(req_tdata[60:46]));

   assign left_w     = {1'b0, node_ff, 1'b1};
   assign right_w    = left_w + CH_W'(1);
   assign count_w    = CH_W'(count_ff);
   assign node_m1    = node_ff - IDX_W'(1);
   assign parent_idx = node_m1 >> 1;
   assign idx_next   = idx_ff + IDX_W'(1);
   assign count_m1   = count_ff - CNT_W'(1);
   assign last_idx   = count_m1[IDX_W-1:0];

   // sift-down choice: left wins a tie, a child must be strictly greater
   assign left_gt  = child_ff.key > item_ff.key;
   assign best_key = left_gt ? child_ff.key : item_ff.key;
   assign right_gt = (right_w < count_w) && (rdata_ff.key > best_key);

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (cmd.rd_sel)
         mhpq_pkg::RD_ROOT:   rd_addr = '0;
         mhpq_pkg::RD_NEXT:   rd_addr = idx_next;
         mhpq_pkg::RD_PARENT: rd_addr = parent_idx;
         mhpq_pkg::RD_LAST:   rd_addr = last_idx;
         mhpq_pkg::RD_LEFT:   rd_addr = left_w[IDX_W-1:0];
         mhpq_pkg::RD_RIGHT:  rd_addr = right_w[IDX_W-1:0];
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         mhpq_pkg::WR_ITEM:   wr_data = item_ff;
         mhpq_pkg::WR_PARENT: wr_data = rdata_ff;
         mhpq_pkg::WR_CHILD:  wr_data = right_gt ? rdata_ff : child_ff;
         default:             wr_data = item_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         heap_mem[node_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= heap_mem[rd_addr];
      end
   end

   always_comb begin
      count_in      = count_ff;
      node_in       = node_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      child_in      = child_ff;
      func_in       = func_ff;
      moved_in      = moved_ff;
      status_in     = status_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_out_in    = rsp_out_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (cmd.load_req) begin
         func_in     = mhpq_pkg::func_type'(req_tuser);
         item_in.id  = req_tdata[15:0];
         item_in.key = key_sum;
         idx_in      = '0;
         moved_in    = 1'b0;
         status_in   = mhpq_pkg::STATUS_OK;
         out_in      = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_m1;
      end
      if (cmd.item_from_rdata) begin
         item_in = rdata_ff;
      end
      if (cmd.latch_out) begin
         out_in = rdata_ff;
      end
      if (cmd.latch_child) begin
         child_in = rdata_ff;
      end
      if (cmd.moved_set) begin
         moved_in = 1'b1;
      end
      if (cmd.status_set) begin
         status_in = cmd.status_code;
      end

      case (cmd.node_sel)
         mhpq_pkg::NODE_HOLD:   node_in = node_ff;
         mhpq_pkg::NODE_COUNT:  node_in = count_ff[IDX_W-1:0];
         mhpq_pkg::NODE_IDX:    node_in = idx_ff;
         mhpq_pkg::NODE_PARENT: node_in = parent_idx;
         mhpq_pkg::NODE_ZERO:   node_in = '0;
         mhpq_pkg::NODE_CHILD:  node_in = right_gt ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
         default:               node_in = node_ff;
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_out_in    = out_ff;
         rsp_occ_in    = mhpq_pkg::OCC_W'(count_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         moved_ff     <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         moved_ff     <= moved_in;
      end
      node_ff       <= node_in;
      idx_ff        <= idx_in;
      item_ff       <= item_in;
      child_ff      <= child_in;
      func_ff       <= func_in;
      status_ff     <= status_in;
      out_ff        <= out_in;
      rsp_status_ff <= rsp_status_in;
      rsp_out_ff    <= rsp_out_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign sts.func        = func_ff;
   assign sts.count_zero  = (count_ff == '0);
   assign sts.count_full  = (count_ff == DEPTH_C);
   assign sts.node_zero   = (node_ff == '0);
   assign sts.parent_less = (rdata_ff.key < item_ff.key);
   assign sts.id_match    = (rdata_ff.id == item_ff.id);
   assign sts.search_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign sts.left_in     = (left_w < count_w);
   assign sts.right_in    = (right_w < count_w);
   assign sts.down_move   = left_gt || right_gt;
   assign sts.moved       = moved_ff;
   assign sts.rsp_free    = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_out_ff.key, rsp_out_ff.id};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above heap depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en && (count_ff != '0) |-> (CNT_W'(node_ff) < count_ff))
      else $error("entry write outside the occupied heap");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("result loaded over an untaken beat");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && (status_ff != mhpq_pkg::STATUS_OK) |=> (rsp_out_ff == '0))
      else $error("failed operation returned a nonzero entry");

endmodule

### rtl/mhpq_controller.sv
module mhpq_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mhpq_pkg::sts_type sts,
   output mhpq_pkg::cmd_type cmd
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_DISPATCH = 11'b000_0000_0010,
      ST_SRCH     = 11'b000_0000_0100,
      ST_UP_RD    = 11'b000_0000_1000,
      ST_UP_CMP   = 11'b000_0001_0000,
      ST_EX_ROOT  = 11'b000_0010_0000,
      ST_EX_LAST  = 11'b000_0100_0000,
      ST_DN_L     = 11'b000_1000_0000,
      ST_DN_R     = 11'b001_0000_0000,
      ST_DN_CMP   = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      down_after_up;

   // an update whose entry did not rise goes on to sift down
   assign down_after_up = (sts.func == mhpq_pkg::FUNC_UPDATE) && !sts.moved;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            case (sts.func)
               mhpq_pkg::FUNC_INSERT: begin
                  if (sts.count_full) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = mhpq_pkg::STATUS_FULL;
                     state_in        = ST_DONE;
                  end else begin
                     cmd.node_sel  = mhpq_pkg::NODE_COUNT;
                     cmd.count_inc = 1'b1;
                     state_in      = ST_UP_RD;
                  end
               end
               mhpq_pkg::FUNC_EXTRACT: begin
                  if (sts.count_zero) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = mhpq_pkg::STATUS_EMPTY;
                     state_in        = ST_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = mhpq_pkg::RD_ROOT;
                     state_in   = ST_EX_ROOT;
                  end
               end
               mhpq_pkg::FUNC_UPDATE: begin
                  if (sts.count_zero) begin
                     cmd.status_set  = 1'b1;
                     cmd.status_code = mhpq_pkg::STATUS_NOT_FOUND;
                     state_in        = ST_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = mhpq_pkg::RD_ROOT;
                     state_in   = ST_SRCH;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_SRCH: begin
            if (sts.id_match) begin
               cmd.node_sel = mhpq_pkg::NODE_IDX;
               state_in     = ST_UP_RD;
            end else if (sts.search_last) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = mhpq_pkg::STATUS_NOT_FOUND;
               state_in        = ST_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = mhpq_pkg::RD_NEXT;
            end
         end

         ST_UP_RD: begin
            if (sts.node_zero) begin
               if (down_after_up) begin
                  state_in = ST_DN_L;
               end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = mhpq_pkg::WR_ITEM;
                  state_in   = ST_DONE;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mhpq_pkg::RD_PARENT;
               state_in   = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            if (sts.parent_less) begin
               // drop the parent into the hole and climb
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = mhpq_pkg::WR_PARENT;
               cmd.node_sel  = mhpq_pkg::NODE_PARENT;
               cmd.moved_set = 1'b1;
               state_in      = ST_UP_RD;
            end else if (down_after_up) begin
               state_in = ST_DN_L;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhpq_pkg::WR_ITEM;
               state_in   = ST_DONE;
            end
         end

         ST_EX_ROOT: begin
            cmd.latch_out = 1'b1;
            cmd.count_dec = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = mhpq_pkg::RD_LAST;
            state_in      = ST_EX_LAST;
         end

         ST_EX_LAST: begin
            cmd.item_from_rdata = 1'b1;
            cmd.node_sel        = mhpq_pkg::NODE_ZERO;
            state_in            = ST_DN_L;
         end

         ST_DN_L: begin
            if (sts.left_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mhpq_pkg::RD_LEFT;
               state_in   = ST_DN_R;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhpq_pkg::WR_ITEM;
               state_in   = ST_DONE;
            end
         end

         ST_DN_R: begin
            cmd.latch_child = 1'b1;
            cmd.rd_en       = sts.right_in;
            cmd.rd_sel      = mhpq_pkg::RD_RIGHT;
            state_in        = ST_DN_CMP;
         end

         ST_DN_CMP: begin
            if (sts.down_move) begin
               // lift the larger child into the hole and descend
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = mhpq_pkg::WR_CHILD;
               cmd.node_sel = mhpq_pkg::NODE_CHILD;
               state_in     = ST_DN_L;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhpq_pkg::WR_ITEM;
               state_in   = ST_DONE;
            end
         end

         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
